// ===== sv/mpq_pkg.sv =====
// Package with the item types, operation codes and controller types of the priority queue.
`timescale 1ns / 1ps

package mpq_pkg;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] top_value;
    logic [3:0]         count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_WR,
    ST_EXT_RD,
    ST_EXT_WR,
    ST_PASS_INIT,
    ST_PASS_RD,
    ST_PASS_CMP,
    ST_PASS_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic ins_write;
    logic ext_read;
    logic ext_write;
    logic pass_init;
    logic pass_read;
    logic swap_lo;
    logic swap_hi;
    logic idx_dec;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic ok;
    logic pass_more;
    logic greater;
    logic out_busy;
  } status_t;

endpackage

// ===== sv/max_priority_queue.sv =====
// Top level of the max priority queue: controller and datapath.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  in_data   (op, value)
// out      output     out_valid/ out_ready out_data  (ok, top_value, count)
//
// An accepted insert writes the new entry, then runs the reorder pass; an accepted extract
// moves the last entry to the root, then runs the pass. The pass covers every index from the
// new last entry down to 1, swapping an entry with its parent where it is greater. A refused
// item goes straight to its result. The entry memory has one write port, so a swap takes two
// writes, child first. Reset empties the queue at once; no clearing pass is needed.
// A waiting result holds the block in its last state; the next item is taken only after the
// new result is loaded and the block is back in idle, in the cycle after that.
`timescale 1ns / 1ps

module max_priority_queue import mpq_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t status;

  mpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sv/mpq_ctrl.sv =====
// Controller state machine that sequences insert, extract and the reorder pass.
`timescale 1ns / 1ps

module mpq_ctrl import mpq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!status.ok) begin
          state_next = ST_DONE;
        end else if (status.op == OP_INSERT) begin
          state_next = ST_INS_WR;
        end else begin
          state_next = ST_EXT_RD;
        end
      end
      ST_INS_WR:    state_next = ST_PASS_INIT;
      ST_EXT_RD:    state_next = ST_EXT_WR;
      ST_EXT_WR:    state_next = ST_PASS_INIT;
      ST_PASS_INIT: state_next = ST_PASS_RD;
      ST_PASS_RD: begin
        state_next = status.pass_more ? ST_PASS_CMP : ST_DONE;
      end
      ST_PASS_CMP: begin
        state_next = status.greater ? ST_PASS_WR : ST_PASS_RD;
      end
      ST_PASS_WR:   state_next = ST_PASS_RD;
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_INS_WR:    cmd.ins_write = 1'b1;
      ST_EXT_RD:    cmd.ext_read  = 1'b1;
      ST_EXT_WR:    cmd.ext_write = 1'b1;
      ST_PASS_INIT: cmd.pass_init = 1'b1;
      ST_PASS_RD:   cmd.pass_read = status.pass_more;
      ST_PASS_CMP: begin
        cmd.swap_lo = status.greater;
        cmd.idx_dec = !status.greater;
      end
      ST_PASS_WR: begin
        cmd.swap_hi = 1'b1;
        cmd.idx_dec = 1'b1;
      end
      ST_DONE:      cmd.result_load = !status.out_busy;
      default:      cmd = '0;
    endcase
  end

endmodule

// ===== sv/mpq_dp.sv =====
// Datapath of the priority queue: entry memory, fill count, pass index and result register.
`timescale 1ns / 1ps

module mpq_dp import mpq_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output status_t   status,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_a, rd_b;

  logic [CW-1:0]   fill;
  logic [CW-1:0]   fill_dec;
  logic [CW+3:0]   fill_wide;
  logic [IW-1:0]   idx, parent, last_idx;
  logic [IW-1:0]   rd_addr_a, rd_addr_b, wr_addr;
  logic signed [31:0] wr_data;
  logic            wr_en, rd_en;
  logic            full, empty;

  logic               op_reg, ok_reg;
  logic signed [31:0] value_reg, top_reg;

  assign fill_dec  = fill - CW'(1);
  assign fill_wide = (CW + 4)'(fill);
  assign last_idx  = fill_dec[IW-1:0];
  assign parent    = (idx - IW'(1)) >> 1;
  assign full      = (fill == CW'(CAPACITY));
  assign empty     = (fill == '0);

  always_comb begin
    rd_addr_a = cmd.ext_read ? '0 : idx;
    rd_addr_b = cmd.ext_read ? last_idx : parent;
    rd_en     = cmd.ext_read | cmd.pass_read;
    wr_en     = cmd.ins_write | cmd.ext_write | cmd.swap_lo | cmd.swap_hi;
    wr_addr   = idx;
    wr_data   = rd_b;
    if (cmd.ins_write) begin
      wr_addr = fill[IW-1:0];
      wr_data = value_reg;
    end else if (cmd.ext_write) begin
      wr_addr = '0;
    end else if (cmd.swap_hi) begin
      wr_addr = parent;
      wr_data = rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.ins_write) begin
      fill <= fill + CW'(1);
    end else if (cmd.ext_write) begin
      fill <= fill_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      idx <= empty ? '0 : last_idx;
    end else if (cmd.idx_dec) begin
      idx <= idx - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg    <= in_data.op;
      value_reg <= in_data.value;
      ok_reg    <= (in_data.op == OP_EXTRACT) ? !empty : !full;
      top_reg   <= '0;
    end else if (cmd.ext_write) begin
      top_reg <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data.ok        <= ok_reg;
      out_data.top_value <= top_reg;
      out_data.count     <= fill_wide[3:0];
    end
  end

  always_comb begin
    status.op        = op_reg;
    status.ok        = ok_reg;
    status.pass_more = (idx != '0);
    status.greater   = (rd_a > rd_b);
    status.out_busy  = out_valid & ~out_ready;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    cmd.swap_hi |-> $past(cmd.swap_lo))
    else $error("parent write without preceding child write");

  a_ext_order: assert property (@(posedge clk) disable iff (rst)
    cmd.ext_write |-> $past(cmd.ext_read))
    else $error("root refill without preceding read");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.ok) |-> (out_data.top_value == 0))
    else $error("refused item carries a nonzero top value");
`endif

endmodule
